@@ src/kcsg_pkg.sv @@
// Shared types, constants and helpers for the Koch curve segment generator.
package kcsg_pkg;

  localparam int COORD_W   = 16;
  localparam int DEPTH_W   = 2;
  localparam int KCSG_MAX_DEPTH = 3;
  localparam logic [DEPTH_W-1:0] TREE_DEPTH_RST = 2'd3;

  // datapath widths for 16-bit coordinates
  localparam int SUM_W  = COORD_W + 2;       // 2a+b
  localparam int MAG_W  = COORD_W + 1;       // |2a+b|+1
  localparam int RCP_W  = 16;
  localparam int RCP_SH = 17;
  localparam logic [RCP_W-1:0] RECIP3 = 16'd43691;  // ceil(2^17/3)
  localparam int DIF_W  = COORD_W + 1;
  localparam int SQ_W   = 16;
  localparam logic signed [SQ_W-1:0] SQRT3_Q14 = 16'sd28378;
  localparam int PRD_W  = DIF_W + SQ_W;
  localparam int RND_SH = 14;
  localparam int SAT_W  = COORD_W + 4;

  // pipeline cycle on which the apex is complete
  localparam int CALC_LAST = 6;
  localparam int CNT_W = $clog2(CALC_LAST + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WALK
  } kcsg_state_t;

  typedef struct packed {
    depth_t depth;
    logic   load_top;
    logic   emit_top;
    logic   store_pts;
    logic   push;
    logic   emit;
  } kcsg_cmd_t;

  typedef struct packed {
    logic is_leaf;
    logic last;
    logic out_free;
  } kcsg_stat_t;

  function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      sat_coord = hi[COORD_W-1:0];
    end else if (v < lo) begin
      sat_coord = lo[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

@@ src/kcsg_datapath.sv @@
// Segment stack, subdivision arithmetic pipeline and output register.
module kcsg_datapath #(
  parameter int MAX_DEPTH = kcsg_pkg::KCSG_MAX_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  kcsg_pkg::kcsg_cmd_t  cmd,
  output kcsg_pkg::kcsg_stat_t stat,
  input  kcsg_pkg::coord_t   start_x,
  input  kcsg_pkg::coord_t   start_y,
  input  kcsg_pkg::coord_t   end_x,
  input  kcsg_pkg::coord_t   end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output kcsg_pkg::coord_t   leaf_ax,
  output kcsg_pkg::coord_t   leaf_ay,
  output kcsg_pkg::coord_t   leaf_bx,
  output kcsg_pkg::coord_t   leaf_by,
  output logic               last_leaf
);
  import kcsg_pkg::*;

  localparam int LVL_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  seg_t             seg_stk   [MAX_DEPTH];
  pt_t              d_stk     [MAX_DEPTH];
  pt_t              e_stk     [MAX_DEPTH];
  pt_t              f_stk     [MAX_DEPTH];
  logic [1:0]       child_stk [MAX_DEPTH];
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] nxt;

  seg_t       cur;
  pt_t        cur_d;
  pt_t        cur_e;
  pt_t        cur_f;
  logic [1:0] cur_c;
  seg_t       child_seg;
  seg_t       in_seg;

  logic             found;
  logic [LVL_W-1:0] tgt;

  // arithmetic pipeline, free running on the current level's segment
  logic signed [SUM_W-1:0] sum  [4];
  logic [SUM_W-1:0]        sabs [4];
  logic [MAG_W-1:0]        m0   [4];
  logic                    neg0 [4];
  logic [MAG_W+RCP_W-1:0]  prod [4];
  logic [COORD_W-1:0]      q1   [4];
  logic                    neg1 [4];
  logic signed [SAT_W-1:0] qv   [4];
  coord_t                  de2  [4];
  logic signed [DIF_W-1:0] diff_y;
  logic signed [DIF_W-1:0] diff_x;
  logic signed [PRD_W-1:0] p3_x;
  logic signed [PRD_W-1:0] p3_y;
  logic signed [SAT_W-1:0] px4;
  logic signed [SAT_W-1:0] py4;
  logic signed [SAT_W-1:0] t5_x;
  logic signed [SAT_W-1:0] t5_y;
  pt_t                     f_new;

  assign in_seg = '{ax: start_x, ay: start_y, bx: end_x, by: end_y};
  assign cur    = seg_stk[level];
  assign cur_d  = d_stk[level];
  assign cur_e  = e_stk[level];
  assign cur_f  = f_stk[level];
  assign cur_c  = child_stk[level];
  assign nxt    = level + LVL_W'(1);

  always_comb begin
    case (cur_c)
      2'd0: child_seg = '{ax: cur.ax, ay: cur.ay, bx: cur_d.x, by: cur_d.y};
      2'd1: child_seg = '{ax: cur_d.x, ay: cur_d.y, bx: cur_f.x, by: cur_f.y};
      2'd2: child_seg = '{ax: cur_f.x, ay: cur_f.y, bx: cur_e.x, by: cur_e.y};
      default: child_seg = '{ax: cur_e.x, ay: cur_e.y, bx: cur.bx, by: cur.by};
    endcase
  end

  // deepest level at or above the current one that still has a child to go
  always_comb begin
    found = 1'b0;
    tgt   = '0;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (LVL_W'(j) <= level && child_stk[j] != 2'd3) begin
        found = 1'b1;
        tgt   = LVL_W'(j);
      end
    end
  end

  assign stat.is_leaf  = (3'(level) + 3'd1) >= 3'(cmd.depth);
  assign stat.last     = !found;
  assign stat.out_free = !out_valid || !out_stall;

  // one-third points: dx, dy, ex, ey
  always_comb begin
    sum[0] = SUM_W'(cur.ax) + SUM_W'(cur.ax) + SUM_W'(cur.bx);
    sum[1] = SUM_W'(cur.ay) + SUM_W'(cur.ay) + SUM_W'(cur.by);
    sum[2] = SUM_W'(cur.bx) + SUM_W'(cur.bx) + SUM_W'(cur.ax);
    sum[3] = SUM_W'(cur.by) + SUM_W'(cur.by) + SUM_W'(cur.ay);
    for (int i = 0; i < 4; i++) begin
      sabs[i] = sum[i][SUM_W-1] ? SUM_W'(-sum[i]) : SUM_W'(sum[i]);
      prod[i] = m0[i] * RECIP3;
      qv[i]   = SAT_W'({1'b0, q1[i]});
      if (neg1[i]) begin
        qv[i] = -qv[i];
      end
    end
  end

  assign diff_y = DIF_W'(de2[3]) - DIF_W'(de2[1]);
  assign diff_x = DIF_W'(de2[0]) - DIF_W'(de2[2]);

  function automatic logic signed [SAT_W-1:0] round_q14(input logic signed [PRD_W-1:0] p);
    logic [PRD_W-1:0] mag;
    logic [PRD_W-1:0] r;
    mag = p[PRD_W-1] ? PRD_W'(-p) : PRD_W'(p);
    r   = (mag + PRD_W'(1 << (RND_SH - 1))) >> RND_SH;
    round_q14 = p[PRD_W-1] ? -SAT_W'(r) : SAT_W'(r);
  endfunction

  // halve with ties away from zero, then clamp
  function automatic coord_t half_sat(input logic signed [SAT_W-1:0] t);
    logic [SAT_W-1:0]        mag;
    logic [SAT_W-1:0]        h;
    logic signed [SAT_W-1:0] v;
    mag = t[SAT_W-1] ? SAT_W'(-t) : SAT_W'(t);
    h   = (mag + SAT_W'(1)) >> 1;
    v   = t[SAT_W-1] ? -SAT_W'(h) : SAT_W'(h);
    half_sat = sat_coord(v);
  endfunction

  assign f_new = '{x: half_sat(t5_x), y: half_sat(t5_y)};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      neg0[i] <= sum[i][SUM_W-1];
      m0[i]   <= MAG_W'(sabs[i] + SUM_W'(1));
      neg1[i] <= neg0[i];
      q1[i]   <= prod[i][RCP_SH +: COORD_W];
      de2[i]  <= sat_coord(qv[i]);
    end
    p3_x <= diff_y * SQRT3_Q14;
    p3_y <= diff_x * SQRT3_Q14;
    px4  <= round_q14(p3_x);
    py4  <= round_q14(p3_y);
    t5_x <= SAT_W'(de2[2]) + SAT_W'(de2[0]) + px4;
    t5_y <= SAT_W'(de2[1]) + SAT_W'(de2[3]) + py4;
  end

  // stack payload
  always_ff @(posedge clk) begin
    if (cmd.load_top) begin
      seg_stk[0] <= in_seg;
    end
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (cmd.push && LVL_W'(j) == nxt) begin
        seg_stk[j] <= child_seg;
      end
      if (cmd.store_pts && LVL_W'(j) == level) begin
        d_stk[j] <= '{x: de2[0], y: de2[1]};
        e_stk[j] <= '{x: de2[2], y: de2[3]};
        f_stk[j] <= f_new;
      end
    end
  end

  // stack control
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      for (int j = 0; j < MAX_DEPTH; j++) begin
        child_stk[j] <= 2'd0;
      end
    end else if (cmd.load_top) begin
      level        <= '0;
      child_stk[0] <= 2'd0;
    end else if (cmd.push) begin
      level <= nxt;
      for (int j = 0; j < MAX_DEPTH; j++) begin
        if (LVL_W'(j) == nxt) begin
          child_stk[j] <= 2'd0;
        end
      end
    end else if (cmd.emit) begin
      level <= found ? tgt : '0;
      for (int j = 0; j < MAX_DEPTH; j++) begin
        if (LVL_W'(j) <= level) begin
          if (found && LVL_W'(j) == tgt) begin
            child_stk[j] <= child_stk[j] + 2'd1;
          end else if (!found || LVL_W'(j) > tgt) begin
            child_stk[j] <= 2'd0;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_top) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_top) begin
      leaf_ax   <= start_x;
      leaf_ay   <= start_y;
      leaf_bx   <= end_x;
      leaf_by   <= end_y;
      last_leaf <= 1'b1;
    end else if (cmd.emit) begin
      leaf_ax   <= child_seg.ax;
      leaf_ay   <= child_seg.ay;
      leaf_bx   <= child_seg.bx;
      leaf_by   <= child_seg.by;
      last_leaf <= !found;
    end
  end

endmodule

@@ src/kcsg_ctrl.sv @@
// Sequencer for the subdivision walk and the depth register.
module kcsg_ctrl #(
  parameter int MAX_DEPTH = kcsg_pkg::KCSG_MAX_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cfg_wr_en,
  input  kcsg_pkg::depth_t     cfg_wr_data,
  output kcsg_pkg::kcsg_cmd_t  cmd,
  input  kcsg_pkg::kcsg_stat_t stat
);
  import kcsg_pkg::*;

  kcsg_state_t      state;
  kcsg_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  depth_t           tree_depth;
  depth_t           eff_depth;
  logic             in_take;

  assign eff_depth = (tree_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : tree_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_depth <= TREE_DEPTH_RST;
    end else if (cfg_wr_en) begin
      tree_depth <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_take = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.depth  = eff_depth;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        // depth zero passes the beat straight to the output register
        in_stall = !(eff_depth != '0 || stat.out_free);
        if (in_take) begin
          if (eff_depth == '0) begin
            cmd.emit_top = 1'b1;
          end else begin
            cmd.load_top = 1'b1;
            cnt_next     = '0;
            state_next   = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (cnt == CNT_W'(CALC_LAST)) begin
          cmd.store_pts = 1'b1;
          state_next    = ST_WALK;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_WALK: begin
        if (stat.is_leaf) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (stat.last) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          cmd.push   = 1'b1;
          cnt_next   = '0;
          state_next = ST_CALC;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_calc_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && cnt != CNT_W'(CALC_LAST)) |=>
      (state == ST_CALC && cnt == $past(cnt) + CNT_W'(1)))
    else $error("pipeline wait cut short");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_top) |-> stat.out_free)
    else $error("output register overwritten");

  a_push_inner: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.is_leaf)
    else $error("push past the leaf level");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.last) |=> state == ST_IDLE)
    else $error("walk continued after final leaf");
`endif

endmodule

@@ src/koch_curve_segment_generator_core.sv @@
// Top level of the Koch curve segment generator.
// One input beat is a segment A-B; the block returns the 4^d leaf segments of
// its Koch curve in drawing order, d = tree_depth capped at MAX_DEPTH, with
// last_leaf set on the final one. Depth zero returns the segment itself
// through the output register. Otherwise every interior segment of the tree
// runs once through a pipeline (divide by three, sqrt(3) multiply, rounding)
// that fills in its one-third points and apex. The walk then pushes to the
// deeper level or, at the leaf level, emits each leaf into the output
// register once that register is free. The next segment is taken once the
// final leaf is in the output register.
module koch_curve_segment_generator_core #(
  parameter int MAX_DEPTH = kcsg_pkg::KCSG_MAX_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  kcsg_pkg::depth_t cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  kcsg_pkg::coord_t start_x,
  input  kcsg_pkg::coord_t start_y,
  input  kcsg_pkg::coord_t end_x,
  input  kcsg_pkg::coord_t end_y,
  output logic             out_valid,
  input  logic             out_stall,
  output kcsg_pkg::coord_t leaf_ax,
  output kcsg_pkg::coord_t leaf_ay,
  output kcsg_pkg::coord_t leaf_bx,
  output kcsg_pkg::coord_t leaf_by,
  output logic             last_leaf
);
  import kcsg_pkg::*;

  kcsg_cmd_t  cmd;
  kcsg_stat_t stat;

  kcsg_ctrl #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

  kcsg_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .leaf_ax   (leaf_ax),
    .leaf_ay   (leaf_ay),
    .leaf_bx   (leaf_bx),
    .leaf_by   (leaf_by),
    .last_leaf (last_leaf)
  );

endmodule
